// ===== src/sbs_pkg.sv =====
// Shared types and fixed widths for the segmented boxcar smoother.
`default_nettype none
package sbs_pkg;

  localparam int SAMPLE_W = 32;
  localparam int TAG_W    = 16;
  localparam int CFG_W    = 6;
  localparam int LEN_W    = 6;
  localparam logic [LEN_W-1:0] LEN_MAX = 6'd63;

  // Per-beat commands from the sequencer to every channel lane.
  typedef struct packed {
    logic clr;
    logic acc_en;
    logic acc_double;
    logic raw_load;
    logic div_start;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== src/sbs_lane.sv =====
// One channel lane: window accumulator, serial divider and result register.
`default_nettype none
module sbs_lane
  import sbs_pkg::*;
#(
  parameter int ACCW = 40,
  parameter int DENW = 7
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lane_ctrl_t          ctrl,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic [DENW-1:0]     den,
  output logic [SAMPLE_W-1:0]      result,
  output logic                     done
);

  localparam int CW = $clog2(ACCW + 1);

  logic signed [ACCW-1:0] acc;
  logic [ACCW-1:0]        quo;
  logic [DENW-1:0]        rem;
  logic [CW-1:0]          cnt;
  logic                   neg;
  logic                   busy;
  logic [DENW:0]          trial;
  logic signed [ACCW-1:0] addend;

  assign addend = ctrl.acc_double
                ? (ACCW'(signed'(sample)) <<< 1)
                : ACCW'(signed'(sample));
  assign trial  = {rem, quo[ACCW-1]};
  assign done   = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctrl.div_start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + addend;
    end
    if (ctrl.raw_load) begin
      result <= sample;
    end
    if (ctrl.div_start) begin
      neg <= acc[ACCW-1];
      quo <= acc[ACCW-1] ? ACCW'(-acc) : ACCW'(acc);
      rem <= '0;
      cnt <= CW'(ACCW);
    end else if (busy) begin
      if (cnt != '0) begin
        // Restoring division, one quotient bit per cycle.
        if (trial >= {1'b0, den}) begin
          rem <= DENW'(trial - {1'b0, den});
          quo <= {quo[ACCW-2:0], 1'b1};
        end else begin
          rem <= trial[DENW-1:0];
          quo <= {quo[ACCW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end else begin
        result <= neg ? SAMPLE_W'(-quo[SAMPLE_W-1:0]) : quo[SAMPLE_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/sbs_out.sv =====
// Merge stage: packs the lane results into the output register.
`default_nettype none
module sbs_out
  import sbs_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire logic [SAMPLE_W-1:0]          lane_res [CHANNELS],
  input  wire logic                         smooth,
  input  wire logic                         last,
  output logic                              free,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [CHANNELS*SAMPLE_W-1:0]      m_tdata,
  output logic                              m_tuser,
  output logic                              m_tlast
);

  logic [CHANNELS*SAMPLE_W-1:0] packed_res;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      packed_res[c*SAMPLE_W +: SAMPLE_W] = lane_res[c];
    end
  end

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load && free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load && free) begin
      m_tdata <= packed_res;
      m_tuser <= smooth;
      m_tlast <= last;
    end
  end

endmodule
`default_nettype wire

// ===== src/segmented_boxcar_smoother_unit.sv =====
// Top level of the segmented boxcar smoother: sequencer, sample store, lanes.
//
//  Channel   | Direction | Beat contents
//  ----------+-----------+-------------------------------------------------------
//  cfg       | in        | cfg_wdata = window_size (N), written when cfg_we is high
//  s_axis    | in        | tdata: channel0_in..channelN_in; tuser: source_id,
//            |           | state_id; tlast: end_of_data
//  m_axis    | out       | tdata: channel0_out..channelN_out; tuser: was_smoothed;
//            |           | tlast: last_of_run
//
// One input beat is taken at a time. A raw result passes through check, store read
// and emit; an averaged one takes 2*(N/2)+1 store reads plus the serial divider,
// which works through ACCW quotient bits (ACCW = 40 at the default sizes).
// Each input beat also adds bookkeeping steps in the check state.
// A tag change or end of data adds one raw result per pending sample.
// rst is synchronous and clears all control state; the sample store is not
// cleared, since only samples of the open segment are ever read.
// A stalled output only holds the sequencer in its emit state; nothing is lost.
`default_nettype none
module segmented_boxcar_smoother_unit
  import sbs_pkg::*;
#(
  parameter int MAX_WINDOW = 32,
  parameter int CHANNELS   = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [CHANNELS*SAMPLE_W-1:0]  s_tdata,   // channel0_in, channel1_in, ...
  input  wire logic [2*TAG_W-1:0]            s_tuser,   // source_id, state_id
  input  wire logic                          s_tlast,   // end_of_data
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [CHANNELS*SAMPLE_W-1:0]       m_tdata,   // channel0_out, channel1_out, ...
  output logic                               m_tuser,   // was_smoothed
  output logic                               m_tlast    // last_of_run
);

  localparam int HALF_MAX = MAX_WINDOW / 2;
  localparam int DEPTH    = 2 * HALF_MAX + 1;
  localparam int AW       = $clog2(DEPTH);
  localparam int NW       = $clog2(MAX_WINDOW + 1);
  localparam int DENW     = NW + 1;
  localparam int PW       = $clog2(HALF_MAX + 2);
  localparam int ROW_W    = CHANNELS * SAMPLE_W;
  localparam int ACCW     = SAMPLE_W + 1 + $clog2(2 * DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_RAW, ST_ACC, ST_ACC_END, ST_DSTART, ST_DIV, ST_EMIT
  } state_t;

  // Phases of one input item, in the order they are handled.
  typedef enum logic [1:0] {PH_OLD, PH_INS, PH_MAIN, PH_EOD} phase_t;

  state_t state;
  phase_t phase;

  logic [CFG_W-1:0] window_size;
  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_data;
  logic [AW-1:0]    wp;
  logic [AW-1:0]    wp_inc;
  logic [PW-1:0]    pending;
  logic [LEN_W-1:0] seg_len;
  logic             seg_open;
  logic [TAG_W-1:0] seg_src;
  logic [TAG_W-1:0] seg_st;
  logic [TAG_W-1:0] tag_src;
  logic [TAG_W-1:0] tag_st;
  logic             eod;
  logic [AW-1:0]    emit_age;
  logic             emit_smooth;
  logic             emit_last;
  logic [AW-1:0]    k;
  logic             rd_v;
  logic             rd_end;

  logic [NW-1:0]    n_c;
  logic [NW-1:0]    d_c;
  logic [DENW-1:0]  den;
  logic [AW-1:0]    age_c;
  logic [AW-1:0]    rd_age;
  logic [AW-1:0]    rd_addr;
  logic             smooth_c;
  logic             s_acc;
  logic             out_free;
  logic [CHANNELS-1:0] lane_done;
  logic [SAMPLE_W-1:0] lane_res [CHANNELS];
  lane_ctrl_t       ctrl;

  // Window length clamped to the store, and its half width.
  assign n_c   = (int'(window_size) > MAX_WINDOW) ? NW'(MAX_WINDOW) : NW'(window_size);
  assign d_c   = (n_c >= NW'(2)) ? (n_c >> 1) : '0;
  // Even N: inner samples count twice and the sum is divided by 2N.
  assign den   = n_c[0] ? DENW'(n_c) : {n_c, 1'b0};
  assign age_c = AW'(pending - PW'(1));
  assign smooth_c = (d_c != '0) && (int'(age_c) >= int'(d_c))
                 && (int'(seg_len) >= int'(age_c) + int'(d_c) + 1);

  assign wp_inc = (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  // The store is a ring; age 0 is the newest sample at wp.
  always_comb begin
    if (state == ST_ACC) begin
      rd_age = AW'((AW+1)'(emit_age) + (AW+1)'(k) - (AW+1)'(d_c));
    end else begin
      rd_age = age_c;
    end
    if (rd_age > wp) begin
      rd_addr = AW'((AW+1)'(wp) + (AW+1)'(DEPTH) - (AW+1)'(rd_age));
    end else begin
      rd_addr = wp - rd_age;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      mem[wp_inc] <= s_tdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= '0;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  always_comb begin
    ctrl.clr        = (state == ST_CHECK);
    ctrl.acc_en     = rd_v;
    ctrl.acc_double = rd_v && !rd_end && !n_c[0];
    ctrl.raw_load   = (state == ST_RAW);
    ctrl.div_start  = (state == ST_DSTART);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_OLD;
      rd_v     <= 1'b0;
      wp       <= '0;
      pending  <= '0;
      seg_len  <= '0;
      seg_open <= 1'b0;
      seg_src  <= '0;
      seg_st   <= '0;
    end else begin
      // A store row read in an accumulate cycle is added in the cycle after.
      rd_v <= (state == ST_ACC);
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            tag_src <= s_tuser[TAG_W-1:0];
            tag_st  <= s_tuser[2*TAG_W-1:TAG_W];
            eod     <= s_tlast;
            if (seg_open && (s_tuser[TAG_W-1:0] != seg_src
                             || s_tuser[2*TAG_W-1:TAG_W] != seg_st)) begin
              phase <= PH_OLD;
            end else begin
              phase <= PH_INS;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          case (phase)
            PH_OLD: begin
              // Tags changed: the old segment's pending samples leave raw.
              if (pending != '0) begin
                emit_age    <= age_c;
                emit_smooth <= 1'b0;
                emit_last   <= (pending == PW'(1)) && (d_c != '0) && !eod;
                pending     <= pending - 1'b1;
                state       <= ST_RAW;
              end else begin
                seg_len <= '0;
                phase   <= PH_INS;
              end
            end
            PH_INS: begin
              wp       <= wp_inc;
              seg_len  <= (seg_len < LEN_MAX) ? seg_len + 1'b1 : seg_len;
              pending  <= pending + 1'b1;
              seg_open <= 1'b1;
              seg_src  <= tag_src;
              seg_st   <= tag_st;
              phase    <= PH_MAIN;
            end
            PH_MAIN: begin
              if (int'(pending) > int'(d_c)) begin
                emit_age    <= age_c;
                emit_smooth <= smooth_c;
                emit_last   <= (int'(pending) - 1 <= int'(d_c))
                            && (!eod || pending == PW'(1));
                pending     <= pending - 1'b1;
                k           <= '0;
                state       <= smooth_c ? ST_ACC : ST_RAW;
              end else if (eod) begin
                phase <= PH_EOD;
              end else begin
                state <= ST_IDLE;
              end
            end
            PH_EOD: begin
              if (pending != '0) begin
                emit_age    <= age_c;
                emit_smooth <= 1'b0;
                emit_last   <= (pending == PW'(1));
                pending     <= pending - 1'b1;
                state       <= ST_RAW;
              end else begin
                seg_open <= 1'b0;
                seg_len  <= '0;
                state    <= ST_IDLE;
              end
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_RAW: begin
          state <= ST_EMIT;
        end
        ST_ACC: begin
          // One store row per cycle, newest end of the window first.
          rd_end <= (k == '0) || (int'(k) == 2 * int'(d_c));
          if (int'(k) == 2 * int'(d_c)) begin
            state <= ST_ACC_END;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_ACC_END: begin
          state <= ST_DSTART;
        end
        ST_DSTART: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (&lane_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_CHECK;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    sbs_lane #(
      .ACCW (ACCW),
      .DENW (DENW)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .sample (rd_data[c*SAMPLE_W +: SAMPLE_W]),
      .den    (den),
      .result (lane_res[c]),
      .done   (lane_done[c])
    );
  end

  sbs_out #(
    .CHANNELS (CHANNELS)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (state == ST_EMIT),
    .lane_res (lane_res),
    .smooth   (emit_smooth),
    .last     (emit_last),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/sv/sbs_checker.sv =====
// Checker for the boxcar smoother: watches both streams, predicts and compares results.
module sbs_checker
  import sbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  input  wire logic [4*SAMPLE_W-1:0] s_tdata,
  input  wire logic [2*TAG_W-1:0]   s_tuser,
  input  wire logic                 s_tlast,
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic [4*SAMPLE_W-1:0] m_tdata,
  input  wire logic                 m_tuser,
  input  wire logic                 m_tlast,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF = 16;
  localparam int DEPTH = 2 * HALF + 1;

  typedef struct packed {
    logic [4*SAMPLE_W-1:0] data;
    logic                  smoothed;
    logic                  last;
  } result_t;

  result_t expected_q[$];
  logic signed [SAMPLE_W-1:0] hist [DEPTH][4];
  logic [TAG_W-1:0] seg_src, seg_st;
  logic seg_open;
  int   seg_len, held, win;

  assign pending = expected_q.size();

  function automatic result_t make_result(int age, bit smooth, int n);
    result_t r;
    longint inner, ends, num, den;
    int d;
    d = n / 2;
    r.data = '0;
    for (int c = 0; c < 4; c++) begin
      if (smooth) begin
        inner = 0;
        for (int j = age - d + 1; j < age + d; j++) inner += hist[j][c];
        ends = longint'(hist[age-d][c]) + longint'(hist[age+d][c]);
        if (n % 2 == 0) begin
          num = 2 * inner + ends;
          den = 2 * n;
        end else begin
          num = inner + ends;
          den = n;
        end
        r.data[c*SAMPLE_W +: SAMPLE_W] = 32'(num / den);
      end else begin
        r.data[c*SAMPLE_W +: SAMPLE_W] = hist[age][c];
      end
    end
    r.smoothed = smooth;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic report(string what);
    $display("checker: mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic predict_beat();
    int n, d, first, age;
    logic [TAG_W-1:0] src, st;
    result_t r;
    n = (win > 32) ? 32 : win;
    d = (n >= 2) ? n / 2 : 0;
    src = s_tuser[TAG_W-1:0];
    st  = s_tuser[2*TAG_W-1:TAG_W];
    first = expected_q.size();
    if (seg_open && (src != seg_src || st != seg_st)) begin
      while (held > 0) begin
        held--;
        expected_q = {expected_q, make_result(held, 0, n)};
      end
      seg_len = 0;
    end
    for (int i = DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
    for (int c = 0; c < 4; c++) hist[0][c] = s_tdata[c*SAMPLE_W +: SAMPLE_W];
    if (seg_len < 63) seg_len++;
    held++;
    seg_open = 1;
    seg_src = src;
    seg_st = st;
    while (held > d) begin
      age = held - 1;
      held--;
      expected_q = {expected_q,
                    make_result(age, d > 0 && age >= d && seg_len >= age + d + 1, n)};
    end
    if (s_tlast) begin
      while (held > 0) begin
        held--;
        expected_q = {expected_q, make_result(held, 0, n)};
      end
      seg_open = 0;
      seg_len = 0;
    end
    if (expected_q.size() > first) begin
      r = expected_q[$];
      r.last = 1'b1;
      expected_q[$] = r;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      errors = 0;
      expected_q.delete();
      seg_open = 0;
      seg_len = 0;
      held = 0;
      win = 0;
      seg_src = '0;
      seg_st = '0;
      for (int i = 0; i < DEPTH; i++) for (int c = 0; c < 4; c++) hist[i][c] = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (m_tdata !== e.data)
            report($sformatf("data %h, expected %h", m_tdata, e.data));
          if (m_tuser !== e.smoothed)
            report($sformatf("was_smoothed %b, expected %b", m_tuser, e.smoothed));
          if (m_tlast !== e.last)
            report($sformatf("last_of_run %b, expected %b", m_tlast, e.last));
        end
      end
      if (s_tvalid && s_tready) predict_beat();
      if (cfg_we) win = int'(cfg_wdata);
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the segmented boxcar smoother: stimulus, idling and the verdict.
module tb;
  import sbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [4*SAMPLE_W-1:0] s_tdata = '0;   // channel0_in .. channel3_in
  logic [2*TAG_W-1:0] s_tuser = '0;      // source_id, state_id
  logic s_tlast = 1'b0;                  // end_of_data
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [4*SAMPLE_W-1:0] m_tdata;        // channel0_out .. channel3_out
  logic m_tuser;                         // was_smoothed
  logic m_tlast;                         // last_of_run

  int errors, pending;
  int idle_pct = 32;     // chance in percent that a side idles in a cycle
  int quiet = 0;         // cycles in a row with no beat on either side
  logic [TAG_W-1:0] cur_src = 16'h0001, cur_st = 16'h0002;

  // The slowest case is a smoothed beat at N = 32, with stalls.
  localparam int WATCHDOG = 20000;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  segmented_boxcar_smoother_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  sbs_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .errors(errors), .pending(pending)
  );

  // The receiver stalls at random on the falling edge.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog: any cycle without a beat on either stream counts toward the limit.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Offer one sample beat and hold it until the block takes it.
  task automatic send_sample(logic [4*SAMPLE_W-1:0] data, logic [TAG_W-1:0] src,
                             logic [TAG_W-1:0] st, logic eod);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= {st, src};
    s_tlast <= eod;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait until every expected result has arrived, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Change the window while the block is idle.
  task automatic set_window(int n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [4*SAMPLE_W-1:0] rand_data();
    logic [4*SAMPLE_W-1:0] v;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(5))
        0: v[c*32 +: 32] = 32'h7fffffff;
        1: v[c*32 +: 32] = 32'h80000000;
        2: v[c*32 +: 32] = 32'hffffffff;
        default: v[c*32 +: 32] = $urandom;
      endcase
    end
    return v;
  endfunction

  initial begin
    int windows[6];
    int seg_left;
    windows = '{32, 2, 3, 7, 0, 63};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: pass-through at reset value, extreme samples and tags.
    send_sample({4{32'h7fffffff}}, 16'hffff, 16'hffff, 1'b0);
    send_sample({4{32'h80000000}}, 16'h0000, 16'h0000, 1'b1);
    // N = 4: a short segment, a tag change, then end of data.
    set_window(4);
    for (int i = 0; i < 7; i++) send_sample(rand_data(), 16'h0005, 16'h0001, 1'b0);
    send_sample(rand_data(), 16'h0005, 16'h0002, 1'b0);
    send_sample(rand_data(), 16'h0005, 16'h0002, 1'b1);
    // Largest window with extreme values; the segment is too short for any sample to be smoothed.
    set_window(32);
    for (int i = 0; i < 12; i++)
      send_sample({4{(i % 2) ? 32'h80000000 : 32'h7fffffff}}, 16'h0009, 16'h0009, 1'b0);
    // Window change in mid segment: surplus pending samples go out with the next beat.
    set_window(2);
    send_sample(rand_data(), 16'h0009, 16'h0009, 1'b1);

    // Random part: mostly segments of equal tags with random content.
    for (int k = 0; k < 195; k++) begin
      if (k % 32 == 0) set_window(windows[(k / 32) % 6]);
      if (k == 80) idle_pct = 0;       // a long stretch with no idling
      if (k == 120) idle_pct = 32;
      if (seg_left <= 0) begin
        seg_left = $urandom_range(1, 30);
        if ($urandom_range(3) == 0) cur_src = 16'($urandom);
        else cur_src ^= 16'h1 << $urandom_range(15);
        cur_st = ($urandom_range(1) != 0) ? 16'($urandom) : cur_st;
      end
      seg_left--;
      send_sample(rand_data(), cur_src, cur_st, $urandom_range(24) == 0);
    end
    send_sample(rand_data(), cur_src, cur_st, 1'b1);

    drain();
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
